// File: rtl/hbcd_pkg.sv
// shared types, constants and helpers for the chunked body deframer
// no dependencies; used by hbcd_size_line and http_body_chunked_deframer
package hbcd_pkg;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_BUSY  = 2'd0,
		STATUS_DONE  = 2'd1,
		STATUS_ERROR = 2'd2
	} status_t;

	// configuration register indexes
	localparam logic [1:0] REG_CHUNKED_MODE = 2'd0;
	localparam logic [1:0] REG_LENGTH_KNOWN = 2'd1;
	localparam logic [1:0] REG_BODY_LENGTH  = 2'd2;

	// characters seen in a size line
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	// bytes drained after each chunk's data
	localparam logic [1:0] TRAILER_BYTES = 2'd2;

	// size line parse state apart from its length
	typedef struct packed {
		logic [31:0] accum;
		logic        digit_seen;
		logic        ended;
		logic        bad;
	} line_t;

	// size line outcome toward the body control
	typedef struct packed {
		logic set_error;
		logic set_done;
		logic load_chunk;
	} line_evt_t;

	// hex digit decode: {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// File: rtl/hbcd_size_line.sv
// next-state logic for one byte of a chunk size line
// depends on hbcd_pkg
module hbcd_size_line #(
	parameter int SIZE_LINE_MAX = 32,
	parameter int LW = $clog2(SIZE_LINE_MAX)
) (
	input  logic [7:0]          c,
	input  hbcd_pkg::line_t     line_in,
	input  logic [LW-1:0]       len_in,
	output hbcd_pkg::line_t     line_out,
	output logic [LW-1:0]       len_out,
	output hbcd_pkg::line_evt_t evt
);
	import hbcd_pkg::*;

	logic [4:0]  hex;
	logic        delim;
	logic [LW:0] len_inc;

	assign hex     = hex_decode(c);
	assign delim   = (c == CHAR_SEMI) || (c == CHAR_SPACE) || (c == CHAR_TAB);
	assign len_inc = {1'b0, len_in} + (LW+1)'(1);

	// one size line byte: skip CR, close at LF, else parse or flag overflow
	always_comb begin
		line_out = line_in;
		len_out  = len_in;
		evt      = '0;
		if (c == CHAR_CR) begin
			line_out = line_in;
		end else if (c == CHAR_LF) begin
			if (line_in.bad || !line_in.digit_seen) begin
				evt.set_error = 1'b1;
			end else if (line_in.accum == 32'd0) begin
				evt.set_done = 1'b1;
			end else begin
				evt.load_chunk = 1'b1;
			end
			line_out = '0;
			len_out  = '0;
		end else if (len_inc >= (LW+1)'(SIZE_LINE_MAX)) begin
			evt.set_error = 1'b1;
			line_out      = '0;
			len_out       = '0;
		end else begin
			len_out = len_inc[LW-1:0];
			if (!line_in.ended && !line_in.bad) begin
				if (delim) begin
					line_out.ended = 1'b1;
				end else if (!hex[4] || line_in.accum[31:28] != 4'd0) begin
					line_out.bad = 1'b1;
				end else begin
					line_out.accum      = {line_in.accum[27:0], hex[3:0]};
					line_out.digit_seen = 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/http_body_chunked_deframer.sv
// HTTP body deframer top level: input register, body control and result register
// depends on hbcd_pkg and hbcd_size_line
//
// Usage: body bytes enter on the input channel (in_valid, in_stall, data_byte,
// body_start), one per transfer. Each input transfer yields exactly one result
// transfer on the output channel (out_valid, out_stall, emit, out_byte,
// received_count, status). emit marks a payload byte; status reports in
// progress, body complete or framing error. Set body_start on the first byte
// of a new body to clear all body state before that byte is handled.
// Registers chunked_mode, length_known, body_length are written through cfg_we,
// cfg_index and cfg_data; the user writes only while the block is idle (not enforced).
// A result is offered once its input transfer has passed the input register and
// then the result register, and it transfers while out_stall is low.
// Throughput: one byte per cycle while the receiver does not stall, with the chunk
// and line counters updated combinationally between the two registers.
// When the receiver stalls, the result register holds and the input register
// still fills once, so one further byte is taken before in_stall rises.
// Reset clears the registers, all body state and both pipeline stages.
module http_body_chunked_deframer #(
	parameter int SIZE_LINE_MAX = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 body_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 emit,
	output logic [7:0]           out_byte,
	output logic [31:0]          received_count,
	output hbcd_pkg::status_t    status,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import hbcd_pkg::*;

	localparam int LW = $clog2(SIZE_LINE_MAX);

	// configuration registers
	logic        chunked_mode_q;
	logic        length_known_q;
	logic [31:0] body_length_q;

	// body state
	logic [31:0]   chunk_left_q;
	logic [1:0]    trailer_left_q;
	logic [LW-1:0] line_len_q;
	line_t         line_q;
	logic          body_done_q;
	logic          error_q;
	logic [31:0]   delivered_q;

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// result stage
	logic       valid_s2;
	logic       emit_s2;
	logic [7:0] byte_s2;
	logic [31:0] count_s2;
	status_t    status_s2;

	logic advance;
	logic accept;

	// state as seen by the byte, after an optional body clear
	logic [31:0]   chunk_cur;
	logic [1:0]    trailer_cur;
	logic [LW-1:0] len_cur;
	line_t         line_cur;
	logic          done_cur;
	logic          error_cur;
	logic [31:0]   delivered_cur;

	line_t         line_nx;
	logic [LW-1:0] len_nx;
	line_evt_t     evt;

	logic [31:0]   chunk_d;
	logic [1:0]    trailer_d;
	logic [LW-1:0] len_d;
	line_t         line_d;
	logic          done_d;
	logic          error_d;
	logic [31:0]   delivered_d;
	logic          emit_d;
	status_t       status_d;

	// handshake between stages
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
			length_known_q <= 1'b0;
			body_length_q  <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHUNKED_MODE: chunked_mode_q <= cfg_data[0];
				REG_LENGTH_KNOWN: length_known_q <= cfg_data[0];
				REG_BODY_LENGTH:  body_length_q  <= cfg_data;
				default:          chunked_mode_q <= chunked_mode_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_byte;
			start_s1 <= body_start;
		end
	end

	// body clear ahead of the byte
	always_comb begin
		chunk_cur     = start_s1 ? 32'd0 : chunk_left_q;
		trailer_cur   = start_s1 ? 2'd0 : trailer_left_q;
		len_cur       = start_s1 ? '0 : line_len_q;
		line_cur      = start_s1 ? '0 : line_q;
		done_cur      = start_s1 ? 1'b0 : body_done_q;
		error_cur     = start_s1 ? 1'b0 : error_q;
		delivered_cur = start_s1 ? 32'd0 : delivered_q;
	end

	hbcd_size_line #(
		.SIZE_LINE_MAX(SIZE_LINE_MAX),
		.LW(LW)
	) u_size_line (
		.c       (data_s1),
		.line_in (line_cur),
		.len_in  (len_cur),
		.line_out(line_nx),
		.len_out (len_nx),
		.evt     (evt)
	);

	// body control: raw pass, trailer drain, size line or chunk data
	always_comb begin
		chunk_d     = chunk_cur;
		trailer_d   = trailer_cur;
		len_d       = len_cur;
		line_d      = line_cur;
		done_d      = done_cur;
		error_d     = error_cur;
		delivered_d = delivered_cur;
		emit_d      = 1'b0;
		if (!error_cur && !done_cur) begin
			if (!chunked_mode_q) begin
				if (!length_known_q || delivered_cur < body_length_q) begin
					emit_d      = 1'b1;
					delivered_d = delivered_cur + 32'd1;
				end
			end else if (trailer_cur != 2'd0) begin
				trailer_d = trailer_cur - 2'd1;
			end else if (chunk_cur == 32'd0) begin
				line_d  = line_nx;
				len_d   = len_nx;
				error_d = evt.set_error;
				done_d  = evt.set_done;
				if (evt.load_chunk) begin
					chunk_d = line_cur.accum;
				end
			end else begin
				emit_d      = 1'b1;
				delivered_d = delivered_cur + 32'd1;
				chunk_d     = chunk_cur - 32'd1;
				if (chunk_cur == 32'd1) begin
					trailer_d = TRAILER_BYTES;
				end
			end
		end
	end

	// status after the byte
	always_comb begin
		if (error_d) begin
			status_d = STATUS_ERROR;
		end else if (done_d) begin
			status_d = STATUS_DONE;
		end else if (!chunked_mode_q && length_known_q && delivered_d >= body_length_q) begin
			status_d = STATUS_DONE;
		end else begin
			status_d = STATUS_BUSY;
		end
	end

	// body state update, one byte per transfer into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_left_q   <= 32'd0;
			trailer_left_q <= 2'd0;
			line_len_q     <= '0;
			line_q         <= '0;
			body_done_q    <= 1'b0;
			error_q        <= 1'b0;
			delivered_q    <= 32'd0;
		end else if (advance) begin
			chunk_left_q   <= chunk_d;
			trailer_left_q <= trailer_d;
			line_len_q     <= len_d;
			line_q         <= line_d;
			body_done_q    <= done_d;
			error_q        <= error_d;
			delivered_q    <= delivered_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			emit_s2   <= emit_d;
			byte_s2   <= emit_d ? data_s1 : 8'd0;
			count_s2  <= delivered_d;
			status_s2 <= status_d;
		end
	end

	assign out_valid      = valid_s2;
	assign emit           = emit_s2;
	assign out_byte       = byte_s2;
	assign received_count = count_s2;
	assign status         = status_s2;

	// a pending trailer only follows a finished chunk
	assert property (@(posedge clk) disable iff (!arst_n)
		chunk_left_q != 32'd0 |-> trailer_left_q == 2'd0)
		else $error("trailer pending while chunk data remains");

	// the trailer drain never starts above two bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		trailer_left_q != 2'd3)
		else $error("trailer count out of range");

	// the stored size line stays under its limit
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, line_len_q} < (LW+1)'(SIZE_LINE_MAX))
		else $error("size line length overflow");

	// an emitted byte never carries the error status
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && emit_s2 |-> status_s2 != STATUS_ERROR)
		else $error("payload byte emitted with framing error");

	// a stalled result stage takes no new byte
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> $stable(count_s2) && $stable(status_s2))
		else $error("result overwritten while stalled");

endmodule
